// ===== hdl/arm_pkg.sv =====
// ----------------------------------------------------------------------------
// arm_pkg
// shared types, widths and codes of the rms envelope meter
// ----------------------------------------------------------------------------
`default_nettype none

package arm_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int MAG_W     = SAMPLE_W + 1;
	localparam int COEF_W    = 16;
	localparam int ENV_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int GAIN_FRAC = 8;
	localparam int PUB_W     = 24;
	localparam int SSP_W     = 32;
	localparam int BLOCK_MAX = 4096;
	localparam int CNT_W     = $clog2(BLOCK_MAX + 1);
	localparam int MUL_W     = MAG_W;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int SUM_W     = CNT_W + 2 * MAG_W - 4;
	localparam int DVD_W     = SUM_W + 2;
	localparam int ROOT_W    = (DVD_W + 1) / 2;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 24;

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTACK  = 4'd0,
		REG_RELEASE = 4'd1,
		REG_GAIN    = 4'd2,
		REG_PUBLISH = 4'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_COUNT,
		ST_DIVIDE,
		ST_ROOT,
		ST_SMOOTH_SETUP,
		ST_SMOOTH,
		ST_DECIDE,
		ST_GAIN,
		ST_PUBLISH
	} state_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_of_block;
	} in_item_t;

	typedef struct packed {
		logic [ENV_W-1:0] level;
		logic [ENV_W-1:0] envelope;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

`default_nettype wire

// ===== hdl/arm_mul.sv =====
// ----------------------------------------------------------------------------
// arm_mul
// serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module arm_mul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [arm_pkg::MUL_W-1:0]   a,
	input  wire logic [arm_pkg::MUL_W-1:0]   b,
	output logic      [arm_pkg::PROD_W-1:0]  p,
	output arm_pkg::unit_sts_t               sts
);
	import arm_pkg::*;

	localparam int STEP_W = $clog2(MUL_W);
	localparam logic [STEP_W-1:0] LAST = STEP_W'(MUL_W - 1);

	logic [PROD_W-1:0] p_q;
	logic [MUL_W-1:0]  mcand_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [MUL_W:0]    upper_sum;

	assign upper_sum = {1'b0, p_q[PROD_W-1:MUL_W]} + (p_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q     <= {{MUL_W{1'b0}}, b};
			mcand_q <= a;
		end else if (busy_q) begin
			p_q <= {upper_sum, p_q[MUL_W-1:1]};
		end
	end

	assign p        = p_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

`default_nettype wire

// ===== hdl/arm_div.sv =====
// ----------------------------------------------------------------------------
// arm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module arm_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [arm_pkg::DVD_W-1:0]   dividend,
	input  wire logic [arm_pkg::CNT_W-1:0]   divisor,
	output logic      [arm_pkg::DVD_W-1:0]   quotient,
	output arm_pkg::unit_sts_t               sts
);
	import arm_pkg::*;

	localparam int STEP_W = $clog2(DVD_W);
	localparam logic [STEP_W-1:0] LAST = STEP_W'(DVD_W - 1);

	logic [DVD_W-1:0]  q_q;
	logic [CNT_W-1:0]  d_q;
	logic [CNT_W-1:0]  r_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    r_shift;
	logic [CNT_W:0]    r_diff;
	logic              fits;

	assign r_shift = {r_q, q_q[DVD_W-1]};
	assign fits    = r_shift >= {1'b0, d_q};
	assign r_diff  = r_shift - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[DVD_W-2:0], fits};
			r_q <= fits ? r_diff[CNT_W-1:0] : r_shift[CNT_W-1:0];
		end
	end

	assign quotient = q_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

`default_nettype wire

// ===== hdl/arm_sqrt.sv =====
// ----------------------------------------------------------------------------
// arm_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module arm_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [arm_pkg::DVD_W-1:0]   radicand,
	output logic      [arm_pkg::ROOT_W-1:0]  root,
	output arm_pkg::unit_sts_t               sts
);
	import arm_pkg::*;

	localparam int RAD_W  = 2 * ROOT_W;
	localparam int STEP_W = $clog2(ROOT_W);
	localparam logic [STEP_W-1:0] LAST = STEP_W'(ROOT_W - 1);

	logic [RAD_W-1:0]  x_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W+3:0] rem_shift;
	logic [ROOT_W+3:0] trial;
	logic [ROOT_W+3:0] rem_diff;
	logic              fits;

	assign rem_shift = {rem_q, x_q[RAD_W-1:RAD_W-2]};
	assign trial     = {2'b00, root_q, 2'b01};
	assign fits      = rem_shift >= trial;
	assign rem_diff  = rem_shift - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= RAD_W'(radicand);
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[RAD_W-3:0], 2'b00};
			root_q <= {root_q[ROOT_W-2:0], fits};
			rem_q  <= fits ? rem_diff[ROOT_W+1:0] : rem_shift[ROOT_W+1:0];
		end
	end

	assign root     = root_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

`default_nettype wire

// ===== hdl/audio_rms_envelope_meter_core.sv =====
// ----------------------------------------------------------------------------
// audio_rms_envelope_meter_core
// block rms level meter with attack/release envelope and gain
//
// input channel in_valid/in_ready/in_data carries one pcm sample and a
// last-of-block flag per transaction. the block works on one sample at a
// time: squaring goes through a serial multiplier, and a sample is added
// to the block sum before the next one is taken. a block end (flag set,
// or the block reaching 4096 samples) adds a serial divide, a serial
// square root and a serial multiply for the smoothing; a published block
// adds a serial gain multiply on top.
// a result transaction (level, envelope) is offered on out_valid/out_ready
// only when publish_samples is nonzero and reached. the result sits in an
// output register, so new samples are taken while it waits; a further
// result is held back, with no sample taken, until the receiver has taken
// the earlier one.
// configuration writes on cfg_valid/cfg_index/cfg_data are always taken.
// reset clears the sum, counters and envelope, sets gain to 1.0 and the
// other registers, all but the output data register, to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_rms_envelope_meter_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire arm_pkg::in_item_t               in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output arm_pkg::out_item_t                   out_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [arm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [arm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import arm_pkg::*;

	state_t state_q;
	state_t state_d;

	logic [COEF_W-1:0] attack_q;
	logic [COEF_W-1:0] release_q;
	logic [GAIN_W-1:0] gain_q;
	logic [PUB_W-1:0]  publish_q;

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic [ENV_W-1:0]  env_q;
	logic [SSP_W-1:0]  ssp_q;
	logic              last_q;
	logic [ENV_W-1:0]  rms_q;
	logic              up_q;

	logic              out_valid_q;
	out_item_t         out_q;

	logic              mul_start;
	logic              div_start;
	logic              sqrt_start;
	logic              out_load;
	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_p;
	logic [DVD_W-1:0]  div_q;
	logic [ROOT_W-1:0] root;
	unit_sts_t         mul_sts;
	unit_sts_t         div_sts;
	unit_sts_t         sqrt_sts;

	logic signed [MAG_W-1:0] sample_x;
	logic [MAG_W-1:0]  mag;
	logic [ENV_W-1:0]  rms_sat;
	logic [ENV_W-1:0]  diff;
	logic [ENV_W-1:0]  step;
	logic [SSP_W:0]    ssp_total;
	logic [ENV_W-1:0]  level_sat;
	logic              block_end;
	logic              publish_due;

	assign sample_x = MAG_W'(in_data.sample);
	assign mag      = sample_x[MAG_W-1] ? MAG_W'(-sample_x) : MAG_W'(sample_x);
	assign rms_sat  = (|root[ROOT_W-1:ENV_W]) ? '1 : root[ENV_W-1:0];
	assign diff     = (rms_q > env_q) ? (rms_q - env_q) : (env_q - rms_q);
	assign step     = mul_p[2*ENV_W-1:ENV_W];
	assign ssp_total = {1'b0, ssp_q} + (SSP_W+1)'(count_q);
	assign level_sat = (|mul_p[PROD_W-1:ENV_W+GAIN_FRAC]) ? '1
		: mul_p[ENV_W+GAIN_FRAC-1:GAIN_FRAC];
	assign block_end   = last_q || (count_q >= CNT_W'(BLOCK_MAX));
	assign publish_due = (publish_q != '0) && (ssp_q >= SSP_W'(publish_q));

	arm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.p      (mul_p),
		.sts    (mul_sts)
	);

	arm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_q, 2'b00}),
		.divisor  (count_q),
		.quotient (div_q),
		.sts      (div_sts)
	);

	arm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_q),
		.root     (root),
		.sts      (sqrt_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		mul_start  = 1'b0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		out_load   = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				mul_a    = mag;
				mul_b    = mag;
				if (in_valid) begin
					mul_start = 1'b1;
					state_d   = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				if (mul_sts.done) begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (block_end) begin
					div_start = 1'b1;
					state_d   = ST_DIVIDE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIVIDE: begin
				if (div_sts.done) begin
					sqrt_start = 1'b1;
					state_d    = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (sqrt_sts.done) begin
					state_d = ST_SMOOTH_SETUP;
				end
			end
			ST_SMOOTH_SETUP: begin
				mul_a     = MUL_W'(diff);
				mul_b     = MUL_W'((rms_q > env_q) ? attack_q : release_q);
				mul_start = 1'b1;
				state_d   = ST_SMOOTH;
			end
			ST_SMOOTH: begin
				if (mul_sts.done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				mul_a = MUL_W'(env_q);
				mul_b = MUL_W'(gain_q);
				if (publish_due) begin
					mul_start = 1'b1;
					state_d   = ST_GAIN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_GAIN: begin
				if (mul_sts.done) begin
					state_d = ST_PUBLISH;
				end
			end
			ST_PUBLISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// block accumulation, envelope and publish counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			env_q   <= '0;
			ssp_q   <= '0;
			last_q  <= 1'b0;
			rms_q   <= '0;
			up_q    <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && in_valid) begin
				last_q <= in_data.last_of_block;
			end
			if (state_q == ST_SQUARE && mul_sts.done) begin
				sum_q   <= sum_q + SUM_W'(mul_p);
				count_q <= count_q + CNT_W'(1);
			end
			if (state_q == ST_ROOT && sqrt_sts.done) begin
				rms_q <= rms_sat;
			end
			if (state_q == ST_SMOOTH_SETUP) begin
				up_q <= rms_q > env_q;
			end
			if (state_q == ST_SMOOTH && mul_sts.done) begin
				env_q   <= up_q ? (rms_q - step) : (rms_q + step);
				ssp_q   <= ssp_total[SSP_W] ? '1 : ssp_total[SSP_W-1:0];
				sum_q   <= '0;
				count_q <= '0;
			end
			if (out_load) begin
				ssp_q <= '0;
			end
		end
	end

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= '0;
			release_q <= '0;
			gain_q    <= GAIN_RESET;
			publish_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_ATTACK:  attack_q  <= cfg_data[COEF_W-1:0];
				REG_RELEASE: release_q <= cfg_data[COEF_W-1:0];
				REG_GAIN:    gain_q    <= cfg_data[GAIN_W-1:0];
				REG_PUBLISH: publish_q <= cfg_data[PUB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.level    <= level_sat;
			out_q.envelope <= env_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BLOCK_MAX))
		else $error("block count above maximum");

	a_accept_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> mul_sts.busy)
		else $error("sample transaction did not start the multiplier");

	a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_sts.busy)
		else $error("multiplier restarted while busy");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |-> (count_q != '0))
		else $error("divide with empty block");

	a_publish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid && ssp_q == '0))
		else $error("publish did not present result and clear counter");

endmodule

`default_nettype wire
